// File: rtl/pbla_pkg.sv
package pbla_pkg;

    // Configuration port geometry
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // Register index, taken from the word address bit
    localparam logic REG_STEP = 1'b0;
    localparam logic REG_BASE = 1'b1;

    localparam logic [11:0] STEP_RESET = 12'd320;
    localparam logic [15:0] BASE_RESET = 16'd31958;

    // One octave in Q.4 cents
    localparam int OCTAVE_Q4 = 19200;
    // 10 Hz in sixteenths of a hertz
    localparam int F0_SCALE = 160;

    // Octave fraction r * 2^16 / 19200 as (r * FRAC_RECIP) >> FRAC_SHIFT, exact for r < 19200
    localparam int FRAC_RECIP = 894785;
    localparam int FRAC_SHIFT = 18;

    typedef struct packed {
        logic [15:0] activation;
        logic        last_bin;
    } t_bin_in;

    typedef struct packed {
        logic [15:0] frequency;
        logic [15:0] voicing;
    } t_result;

    // 2^(k/16) in Q.16 for k = 0..16
    function automatic logic [17:0] exp2_entry(input logic [4:0] k);
        logic [17:0] v;
        unique case (k)
            5'd0:    v = 18'd65536;
            5'd1:    v = 18'd68438;
            5'd2:    v = 18'd71468;
            5'd3:    v = 18'd74632;
            5'd4:    v = 18'd77936;
            5'd5:    v = 18'd81386;
            5'd6:    v = 18'd84990;
            5'd7:    v = 18'd88752;
            5'd8:    v = 18'd92682;
            5'd9:    v = 18'd96785;
            5'd10:   v = 18'd101070;
            5'd11:   v = 18'd105545;
            5'd12:   v = 18'd110218;
            5'd13:   v = 18'd115098;
            5'd14:   v = 18'd120194;
            5'd15:   v = 18'd125515;
            5'd16:   v = 18'd131072;
            default: v = 18'd131072;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/pbla_bin_ram.sv
module pbla_bin_ram #(
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [15:0]              i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [15:0]              o_rd_data
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rd_data;

    // Write one bin per beat
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, held between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/pbla_div.sv
module pbla_div #(
    parameter int N = 42,
    parameter int D = 20
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [N-1:0] i_dividend,
    input  logic [D-1:0] i_divisor,
    output logic         o_done,
    output logic [N-1:0] o_quot
);

    localparam int CW = $clog2(N + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [N-1:0]  r_quot;
    logic [D-1:0]  r_rem;
    logic [D-1:0]  r_div;

    logic [D:0]    shifted;
    logic [D:0]    diff;
    logic          ge;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        shifted = {r_rem, r_quot[N-1]};
        diff    = shifted - {1'b0, r_div};
        ge      = (shifted >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(N);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[N-2:0], ge};
            r_rem  <= ge ? diff[D-1:0] : shifted[D-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: rtl/pitch_bin_local_average_decoder_core.sv
// Bins: one beat per cycle while busy is low; a bin that is not last leaves busy low.
// Frame end: busy rises after the last bin and stays high through the window walk (ST_READ,
//   ST_MUL, ST_ACC for each of the W window bins, W at most 2*HALF_SPAN+1) and the one-bit-per-cycle
//   mean divide over NUM_W bits (NUM_W = 42 at default parameters), skipped on a zero weight sum.
// Reset (i_rst_n low, synchronous): clears bin count, peak tracker, sequencer, strobe and
//   restores both configuration registers; the bin memory is not cleared. o_done rises as busy falls.
module pitch_bin_local_average_decoder_core #(
    parameter int MAX_BINS  = 512,
    parameter int HALF_SPAN = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  pbla_pkg::t_bin_in     i_bin,
    output logic                  o_done,
    output pbla_pkg::t_result     o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [pbla_pkg::ADDR_W-1:0] paddr,
    input  logic [pbla_pkg::DATA_W-1:0] pwdata,
    output logic [pbla_pkg::DATA_W-1:0] prdata,
    output logic                  pready
);

    import pbla_pkg::*;

    localparam int IW      = $clog2(MAX_BINS);
    localparam int HW      = IW + 1;
    localparam int CNT_W   = $clog2(MAX_BINS + 1);
    localparam int SPAN_W  = $clog2(2 * HALF_SPAN + 1);
    localparam int CENTS_W = ((IW + 12 > 16) ? IW + 12 : 16) + 1;
    localparam int PW      = CENTS_W + 16;
    localparam int NUM_W   = PW + SPAN_W;
    localparam int DEN_W   = 16 + SPAN_W;
    localparam int MA      = (CENTS_W > 20) ? CENTS_W : 20;
    localparam int PRW     = MA + 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RANGE,
        ST_BASE,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_MEAN,
        ST_MEAN_WAIT,
        ST_EXP_INT,
        ST_EXP_INT_WAIT,
        ST_EXP_FRAC,
        ST_EXP_FRAC_WAIT,
        ST_INTERP_MUL,
        ST_INTERP_ADD,
        ST_SCALE,
        ST_OUT
    } t_state;

    t_state          r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [IW-1:0]   r_peak_idx;
    logic [15:0]     r_peak_val;
    logic [IW-1:0]   r_idx;
    logic [IW-1:0]   r_hi;
    logic [CENTS_W-1:0] r_cents;
    logic [CENTS_W-1:0] r_cpeak;
    logic [CENTS_W-1:0] r_mean;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [PRW-1:0]  r_prod;
    logic [3:0]      r_e;
    logic            r_e_big;
    logic [1:0]      r_ebit;
    logic [18:0]     r_oct_rem;
    logic [15:0]     r_frac;
    logic [17:0]     r_m;
    logic            r_done;
    t_result         r_result;
    logic [11:0]     r_step;
    logic [15:0]     r_base;

    logic            accept;
    logic            store_en;
    logic            cfg_wr;
    logic [15:0]     rd_data;
    logic [HW-1:0]   lo_ext;
    logic [HW-1:0]   hi_ext;
    logic [HW-1:0]   top_bin;
    logic [HW-1:0]   peak_plus;
    logic [MA-1:0]   mul_a;
    logic [15:0]     mul_b;
    logic            div_start;
    logic [NUM_W-1:0] div_dividend;
    logic [DEN_W-1:0] div_divisor;
    logic            div_done;
    logic [NUM_W-1:0] div_quot;
    logic [18:0]     oct_step;
    logic [17:0]     tab_lo;
    logic [17:0]     tab_hi;
    logic [12:0]     tab_diff;
    logic [25:0]     interp_sum;
    logic [40:0]     scaled;
    logic [24:0]     freq_full;
    logic [15:0]     freq;

    assign accept   = start && (r_state == ST_IDLE);
    assign store_en = accept && (r_cnt < CNT_W'(MAX_BINS));
    assign busy     = (r_state != ST_IDLE);

    // Configuration registers
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RESET;
            r_base <= BASE_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[ADDR_W-1])
                REG_STEP: r_step <= pwdata[11:0];
                REG_BASE: r_base <= pwdata[15:0];
                default:  r_step <= r_step;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[ADDR_W-1])
            REG_STEP: prdata = DATA_W'(r_step);
            REG_BASE: prdata = DATA_W'(r_base);
            default:  prdata = '0;
        endcase
    end

    // Window bounds around the peak, clipped to the frame
    always_comb begin
        peak_plus = HW'(r_peak_idx) + HW'(HALF_SPAN);
        top_bin   = HW'(r_cnt) - 1'b1;
        lo_ext    = (HW'(r_peak_idx) > HW'(HALF_SPAN)) ?
                    HW'(r_peak_idx) - HW'(HALF_SPAN) : '0;
        hi_ext    = (peak_plus > top_bin) ? top_bin : peak_plus;
    end

    // Octave multiple tried at the current exponent bit
    assign oct_step = 19'(OCTAVE_Q4) << r_ebit;

    // Exp2 table lookup and interpolation slope
    always_comb begin
        tab_lo     = exp2_entry({1'b0, r_frac[15:12]});
        tab_hi     = exp2_entry({1'b0, r_frac[15:12]} + 5'd1);
        tab_diff   = 13'(tab_hi - tab_lo);
        interp_sum = 26'(r_prod[24:0]) + 26'd2048;
    end

    // Shared multiplier operand select
    always_comb begin
        unique case (r_state)
            ST_RANGE: begin
                mul_a = MA'(r_step);
                mul_b = 16'(lo_ext);
            end
            ST_MUL: begin
                mul_a = MA'(r_cents);
                mul_b = rd_data;
            end
            ST_EXP_FRAC: begin
                mul_a = MA'(FRAC_RECIP);
                mul_b = r_oct_rem[15:0];
            end
            ST_INTERP_MUL: begin
                mul_a = MA'(tab_diff);
                mul_b = {4'd0, r_frac[11:0]};
            end
            ST_SCALE: begin
                mul_a = MA'(r_m);
                mul_b = 16'(F0_SCALE);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Divider operands: rounded mean of the window
    always_comb begin
        div_start    = (r_state == ST_MEAN) && (r_den != '0);
        div_dividend = r_num + NUM_W'(r_den >> 1);
        div_divisor  = r_den;
    end

    // Final scale by 2^e with rounding and saturation
    always_comb begin
        scaled    = 41'(r_prod[24:0]) << r_e;
        freq_full = 25'((scaled + 41'd32768) >> 16);
        freq      = (r_e_big || (freq_full > 25'd65535)) ? 16'hFFFF : freq_full[15:0];
    end

    // Sequencer: collect bins, walk the window, divide, convert to hertz
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cnt      <= '0;
            r_peak_idx <= '0;
            r_peak_val <= '0;
            r_done     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (store_en) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (i_bin.activation > r_peak_val) begin
                            r_peak_val <= i_bin.activation;
                            r_peak_idx <= r_cnt[IW-1:0];
                        end
                    end
                    if (accept && i_bin.last_bin) begin
                        r_state <= ST_RANGE;
                    end
                end
                ST_RANGE: begin
                    r_idx   <= lo_ext[IW-1:0];
                    r_hi    <= hi_ext[IW-1:0];
                    r_prod  <= PRW'(mul_a) * PRW'(mul_b);
                    r_num   <= '0;
                    r_den   <= '0;
                    r_state <= ST_BASE;
                end
                ST_BASE: begin
                    r_cents <= CENTS_W'(r_base) + r_prod[CENTS_W-1:0];
                    r_state <= ST_READ;
                end
                ST_READ: begin
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_prod  <= PRW'(mul_a) * PRW'(mul_b);
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    r_num <= r_num + NUM_W'(r_prod[PW-1:0]);
                    r_den <= r_den + DEN_W'(rd_data);
                    if (r_idx == r_peak_idx) begin
                        r_cpeak <= r_cents;
                    end
                    if (r_idx == r_hi) begin
                        r_state <= ST_MEAN;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_cents <= r_cents + CENTS_W'(r_step);
                        r_state <= ST_READ;
                    end
                end
                ST_MEAN: begin
                    if (r_den == '0) begin
                        r_mean  <= r_cpeak;
                        r_state <= ST_EXP_INT;
                    end else begin
                        r_state <= ST_MEAN_WAIT;
                    end
                end
                ST_MEAN_WAIT: begin
                    if (div_done) begin
                        r_mean  <= div_quot[CENTS_W-1:0];
                        r_state <= ST_EXP_INT;
                    end
                end
                // Load the mean; anything at or past 16 octaves saturates
                ST_EXP_INT: begin
                    r_oct_rem <= 19'(r_mean);
                    r_e       <= '0;
                    r_ebit    <= 2'd3;
                    r_e_big   <= (32'(r_mean) >= 32'(16 * OCTAVE_Q4));
                    r_state   <= ST_EXP_INT_WAIT;
                end
                // Compare and subtract one octave multiple per cycle, high bit first
                ST_EXP_INT_WAIT: begin
                    if (r_oct_rem >= oct_step) begin
                        r_oct_rem  <= r_oct_rem - oct_step;
                        r_e[r_ebit] <= 1'b1;
                    end
                    if (r_ebit == 2'd0) begin
                        r_state <= ST_EXP_FRAC;
                    end else begin
                        r_ebit <= r_ebit - 1'b1;
                    end
                end
                ST_EXP_FRAC: begin
                    r_prod  <= PRW'(mul_a) * PRW'(mul_b);
                    r_state <= ST_EXP_FRAC_WAIT;
                end
                ST_EXP_FRAC_WAIT: begin
                    r_frac  <= r_prod[FRAC_SHIFT+15:FRAC_SHIFT];
                    r_state <= ST_INTERP_MUL;
                end
                ST_INTERP_MUL: begin
                    r_prod  <= PRW'(mul_a) * PRW'(mul_b);
                    r_state <= ST_INTERP_ADD;
                end
                ST_INTERP_ADD: begin
                    r_m     <= tab_lo + 18'(interp_sum >> 12);
                    r_state <= ST_SCALE;
                end
                ST_SCALE: begin
                    r_prod  <= PRW'(mul_a) * PRW'(mul_b);
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    r_result.frequency <= freq;
                    r_result.voicing   <= r_peak_val;
                    r_done             <= 1'b1;
                    r_cnt              <= '0;
                    r_peak_idx         <= '0;
                    r_peak_val         <= '0;
                    r_state            <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    pbla_bin_ram #(
        .DEPTH (MAX_BINS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (store_en),
        .i_wr_addr (r_cnt[IW-1:0]),
        .i_wr_data (i_bin.activation),
        .i_rd_en   (r_state == ST_READ),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data)
    );

    pbla_div #(
        .N (NUM_W),
        .D (DEN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

endmodule

// File: rtl/pbla_checker.sv
module pbla_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input pbla_pkg::t_bin_in i_bin,
    input logic              o_done
);

    // A result only shows once the block is free again
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // A bin that is not last leaves the block free for the next beat
    a_bin_stays_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_bin.last_bin) |=> !busy)
        else $error("busy after a non-final bin");

    // The last bin starts the frame-end work
    a_last_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_bin.last_bin) |=> busy)
        else $error("no frame-end work after the last bin");

    // Busy ends only by delivering a result
    a_busy_ends_in_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy dropped without a result");

endmodule

bind pitch_bin_local_average_decoder_core pbla_checker u_chk (.*);
